FILE: hdl/event_id_range_queue_xon_xoff_top_defines.svh
// Assertion macros for the event ID range queue.
`ifndef EVENT_ID_RANGE_QUEUE_XON_XOFF_TOP_DEFINES_SVH
`define EVENT_ID_RANGE_QUEUE_XON_XOFF_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EIRQ_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define EIRQ_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/eirq_pkg.sv
// Shared types and constants for the event ID range queue.
`timescale 1ns / 1ps

package eirq_pkg;

   localparam int RANGE_DEPTH = 64;
   localparam int PTR_W       = $clog2(RANGE_DEPTH);
   localparam int OCC_W       = PTR_W + 1;
   localparam int ID_W        = 32;
   localparam int FUNC_W      = 2;
   localparam int MSG_W       = 2;
   localparam int CSR_INDEX_W = 1;

   localparam logic [ID_W-1:0] PREV_ID_RESET = 32'hff00_0000;
   localparam logic [ID_W-1:0] HIGH_WM_RESET = 32'd1000;
   localparam logic [ID_W-1:0] LOW_WM_RESET  = 32'd500;

   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [MSG_W-1:0] FLOW_NONE   = 2'd0;
   localparam logic [MSG_W-1:0] FLOW_XOFF   = 2'd1;
   localparam logic [MSG_W-1:0] FLOW_XON    = 2'd2;
   localparam logic [MSG_W-1:0] FLOW_UNUSED = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_WM = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_WM  = CSR_INDEX_W'(1);

   typedef struct packed {
      logic capture;   // latch the accepted request
      logic execute;   // apply it to the queue and load the result register
      logic out_take;  // result register drained by the consumer
   } eirq_cmd_type;

   typedef struct packed {
      logic out_valid;
   } eirq_stat_type;

endpackage

FILE: hdl/eirq_ifs.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface eirq_req_if import eirq_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ID_W-1:0]   event_id_in;

   modport source (output valid, func, event_id_in, input ready);
   modport sink   (input valid, func, event_id_in, output ready);
endinterface

interface eirq_rsp_if import eirq_pkg::*; ;
   logic             valid;
   logic             ready;
   logic             event_valid;
   logic [ID_W-1:0]  event_id_out;
   logic [MSG_W-1:0] flow_msg;
   logic             epoch_reset_seen;
   logic             error_flag;

   modport source (output valid, event_valid, event_id_out, flow_msg, epoch_reset_seen,
                   error_flag, input ready);
   modport sink   (input valid, event_valid, event_id_out, flow_msg, epoch_reset_seen,
                   error_flag, output ready);
endinterface

FILE: hdl/eirq_ctrl.sv
// Controller state machine: capture a request, then execute it once the result slot frees.
`timescale 1ns / 1ps

module eirq_ctrl import eirq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          rsp_ready,
   input  eirq_stat_type stat,
   output eirq_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           slot_free;

   assign slot_free = !stat.out_valid || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.capture  = 1'b0;
      cmd.execute  = 1'b0;
      cmd.out_take = stat.out_valid && rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/eirq_dpath.sv
// Datapath: range memories, queue pointers, counters, flow state and result register.
`timescale 1ns / 1ps

module eirq_dpath import eirq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  eirq_cmd_type           cmd,
   output eirq_stat_type          stat,
   input  logic [FUNC_W-1:0]      req_func,
   input  logic [ID_W-1:0]        req_event_id_in,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ID_W-1:0]        csr_wdata,
   output logic                   rsp_event_valid,
   output logic [ID_W-1:0]        rsp_event_id_out,
   output logic [MSG_W-1:0]       rsp_flow_msg,
   output logic                   rsp_epoch_reset_seen,
   output logic                   rsp_error_flag
);

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RANGE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // range memories
   logic [ID_W-1:0]  start_mem_ff [RANGE_DEPTH];
   logic [ID_W-1:0]  end_mem_ff   [RANGE_DEPTH];
   logic [ID_W-1:0]  rd_start_ff, rd_end_ff;
   logic             start_we, end_we;
   logic [PTR_W-1:0] start_addr;
   logic [ID_W-1:0]  start_wdata, end_wdata;

   // queue and flow state
   logic [PTR_W-1:0] head_ptr_ff, head_ptr_in;
   logic [PTR_W-1:0] tail_ptr_ff, tail_ptr_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [ID_W-1:0]  pending_ff, pending_in;
   logic             flow_on_ff, flow_on_in;
   logic [ID_W-1:0]  prev_id_ff, prev_id_in;
   logic [ID_W-1:0]  epoch_cnt_ff, epoch_cnt_in;
   logic [ID_W-1:0]  high_wm_ff, high_wm_in;
   logic [ID_W-1:0]  low_wm_ff, low_wm_in;

   // captured request, with range start and length worked out at capture
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [ID_W-1:0]   first_ff, first_in;
   logic [ID_W-1:0]   len_ff, len_in;
   logic              bad_ff, bad_in;
   logic              epoch_ff, epoch_in;

   // result register
   logic             out_valid_ff, out_valid_in;
   logic             ev_valid_ff, ev_valid_in;
   logic [ID_W-1:0]  ev_id_ff, ev_id_in;
   logic [MSG_W-1:0] msg_ff, msg_in;
   logic             epoch_seen_ff, epoch_seen_in;
   logic             err_ff, err_in;

   always_comb begin
      logic            drop;
      logic [ID_W:0]   sum;
      logic [ID_W-1:0] cnt;

      head_ptr_in   = head_ptr_ff;
      tail_ptr_in   = tail_ptr_ff;
      occ_in        = occ_ff;
      pending_in    = pending_ff;
      flow_on_in    = flow_on_ff;
      prev_id_in    = prev_id_ff;
      epoch_cnt_in  = epoch_cnt_ff;
      high_wm_in    = high_wm_ff;
      low_wm_in     = low_wm_ff;
      func_in       = func_ff;
      id_in         = id_ff;
      first_in      = first_ff;
      len_in        = len_ff;
      bad_in        = bad_ff;
      epoch_in      = epoch_ff;
      out_valid_in  = out_valid_ff;
      ev_valid_in   = ev_valid_ff;
      ev_id_in      = ev_id_ff;
      msg_in        = msg_ff;
      epoch_seen_in = epoch_seen_ff;
      err_in        = err_ff;
      start_we      = 1'b0;
      end_we        = 1'b0;
      start_addr    = tail_ptr_ff;
      start_wdata   = first_ff;
      end_wdata     = id_ff;
      drop          = 1'b0;
      sum           = '0;
      cnt           = pending_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_HIGH_WM: high_wm_in = csr_wdata;
            CSR_LOW_WM:  low_wm_in  = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.capture) begin
         func_in = req_func;
         id_in   = req_event_id_in;
         if (prev_id_ff[ID_W-1 -: 8] == req_event_id_in[ID_W-1 -: 8]) begin
            // start is previous+1; empty or backward when previous >= id
            first_in = prev_id_ff + 1'b1;
            bad_in   = (prev_id_ff >= req_event_id_in);
            len_in   = req_event_id_in - prev_id_ff;
            epoch_in = 1'b0;
         end else begin
            first_in = {req_event_id_in[ID_W-1 -: 8], 24'h0};
            bad_in   = 1'b0;
            len_in   = {8'h0, req_event_id_in[23:0]} + 1'b1;
            epoch_in = 1'b1;
         end
      end

      if (cmd.out_take) begin
         out_valid_in = 1'b0;
      end

      if (cmd.execute) begin
         out_valid_in  = 1'b1;
         ev_valid_in   = 1'b0;
         ev_id_in      = '0;
         msg_in        = FLOW_NONE;
         epoch_seen_in = 1'b0;
         err_in        = 1'b0;
         case (func_ff)
            FUNC_UPDATE: begin
               epoch_seen_in = epoch_ff;
               epoch_cnt_in  = epoch_cnt_ff + ID_W'(epoch_ff);
               prev_id_in    = id_ff;
               drop          = bad_ff || (occ_ff >= OCC_W'(RANGE_DEPTH));
               err_in        = drop;
               if (!drop) begin
                  start_we    = 1'b1;
                  end_we      = 1'b1;
                  tail_ptr_in = next_slot(tail_ptr_ff);
                  occ_in      = occ_ff + 1'b1;
                  sum         = {1'b0, pending_ff} + {1'b0, len_ff};
                  cnt         = sum[ID_W] ? '1 : sum[ID_W-1:0];
               end
               pending_in = cnt;
               if (cnt > high_wm_ff && flow_on_ff) begin
                  msg_in     = FLOW_XOFF;
                  flow_on_in = 1'b0;
               end
            end
            FUNC_POP: begin
               if (!flow_on_ff && pending_ff < low_wm_ff) begin
                  msg_in     = FLOW_XON;
                  flow_on_in = 1'b1;
               end
               if (occ_ff != '0) begin
                  ev_valid_in = 1'b1;
                  ev_id_in    = rd_start_ff;
                  if (rd_start_ff >= rd_end_ff) begin
                     head_ptr_in = next_slot(head_ptr_ff);
                     occ_in      = occ_ff - 1'b1;
                  end else begin
                     start_we    = 1'b1;
                     start_addr  = head_ptr_ff;
                     start_wdata = rd_start_ff + 1'b1;
                  end
                  if (pending_ff != '0) begin
                     pending_in = pending_ff - 1'b1;
                  end
               end
            end
            FUNC_CLEAR: begin
               head_ptr_in = '0;
               tail_ptr_in = '0;
               occ_in      = '0;
               pending_in  = '0;
            end
            default: ;
         endcase
      end
   end

   // memories: one write port each, head entry read into a register every cycle
   always_ff @(posedge clock) begin
      if (start_we) begin
         start_mem_ff[start_addr] <= start_wdata;
      end
      rd_start_ff <= start_mem_ff[head_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (end_we) begin
         end_mem_ff[tail_ptr_ff] <= end_wdata;
      end
      rd_end_ff <= end_mem_ff[head_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ptr_ff  <= '0;
         tail_ptr_ff  <= '0;
         occ_ff       <= '0;
         pending_ff   <= '0;
         flow_on_ff   <= 1'b1;
         prev_id_ff   <= PREV_ID_RESET;
         epoch_cnt_ff <= '0;
         high_wm_ff   <= HIGH_WM_RESET;
         low_wm_ff    <= LOW_WM_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         head_ptr_ff  <= head_ptr_in;
         tail_ptr_ff  <= tail_ptr_in;
         occ_ff       <= occ_in;
         pending_ff   <= pending_in;
         flow_on_ff   <= flow_on_in;
         prev_id_ff   <= prev_id_in;
         epoch_cnt_ff <= epoch_cnt_in;
         high_wm_ff   <= high_wm_in;
         low_wm_ff    <= low_wm_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      id_ff         <= id_in;
      first_ff      <= first_in;
      len_ff        <= len_in;
      bad_ff        <= bad_in;
      epoch_ff      <= epoch_in;
      ev_valid_ff   <= ev_valid_in;
      ev_id_ff      <= ev_id_in;
      msg_ff        <= msg_in;
      epoch_seen_ff <= epoch_seen_in;
      err_ff        <= err_in;
   end

   assign stat.out_valid       = out_valid_ff;
   assign rsp_event_valid      = ev_valid_ff;
   assign rsp_event_id_out     = ev_id_ff;
   assign rsp_flow_msg         = msg_ff;
   assign rsp_epoch_reset_seen = epoch_seen_ff;
   assign rsp_error_flag       = err_ff;

endmodule

FILE: hdl/event_id_range_queue_xon_xoff_top.sv
// A request transfer is captured, then executed; the execute step loads the result register.
// A new request is taken only in IDLE, so not before the previous one has been executed.
// A waiting result does not stop the next request transfer; only its execute step waits.
// Range memories are read through a registered head-entry port, one write port each.
// Reset (synchronous, active high): queue empty, count 0, flow on, previous ID 0xff000000,
// watermarks 1000/500; the range memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`include "event_id_range_queue_xon_xoff_top_defines.svh"

module event_id_range_queue_xon_xoff_top import eirq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   eirq_req_if.sink               req_chan,
   eirq_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ID_W-1:0]        csr_wdata
);

   eirq_cmd_type  cmd;
   eirq_stat_type stat;

   // Controller: IDLE takes a request transfer, EXEC waits for the result slot.
   eirq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: queue state, range arithmetic, flow control and result register.
   eirq_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_func             (req_chan.func),
      .req_event_id_in      (req_chan.event_id_in),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_event_valid      (rsp_chan.event_valid),
      .rsp_event_id_out     (rsp_chan.event_id_out),
      .rsp_flow_msg         (rsp_chan.flow_msg),
      .rsp_epoch_reset_seen (rsp_chan.epoch_reset_seen),
      .rsp_error_flag       (rsp_chan.error_flag)
   );

   // result transfer valid comes straight from the result register
   assign rsp_chan.valid = stat.out_valid;

   // a request transfer puts the controller into EXEC, so no back-to-back transfer
   `EIRQ_ASSERT_NXT(a_req_gap, req_chan.valid && req_chan.ready, !req_chan.ready,
                    "request accepted in consecutive cycles")
   // capture and execute never coincide
   `EIRQ_ASSERT_IMP(a_cmd_excl, 1'b1, !(cmd.capture && cmd.execute),
                    "capture and execute in the same cycle")
   // execute always loads the result register
   `EIRQ_ASSERT_NXT(a_exec_load, cmd.execute, rsp_chan.valid,
                    "execute did not load a result")
   // no delivered ID means a zero ID field, and the flow code is never the unused one
   `EIRQ_ASSERT_IMP(a_rsp_fields, rsp_chan.valid,
                    (rsp_chan.event_valid || rsp_chan.event_id_out == '0) &&
                    (rsp_chan.flow_msg != FLOW_UNUSED),
                    "malformed result fields")

endmodule
